### hdl/pu_pkg.sv
// ----------------------------------------------------------------------------
// pu_pkg
// Shared types, microcode table and factorial table for permutation_unrank.
// ----------------------------------------------------------------------------
package pu_pkg;

    localparam int MAX_ELEMENTS_DEF = 12;
    localparam int SIZE_W           = 4;
    localparam int RANK_W           = 29;
    localparam int ELEM_W           = 4;
    localparam int FACT_W           = RANK_W + 1;
    localparam int STEP_W           = 4;

    typedef struct packed {
        logic [SIZE_W-1:0] set_size;
        logic [RANK_W-1:0] rank;
    } t_in_word;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              last;
        logic              rank_error;
    } t_out_word;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_IDLE     = STEP_W'(0);
    localparam t_step ST_CHECK    = STEP_W'(1);
    localparam t_step ST_FACT     = STEP_W'(2);
    localparam t_step ST_DIV      = STEP_W'(3);
    localparam t_step ST_WAIT     = STEP_W'(4);
    localparam t_step ST_EMIT     = STEP_W'(5);
    localparam t_step ST_DONE     = STEP_W'(6);
    localparam t_step ST_ERR_WAIT = STEP_W'(7);
    localparam t_step ST_ERR_EMIT = STEP_W'(8);

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_BAD,
        C_FIT,
        C_OUT_FULL,
        C_MORE
    } t_cond;

    typedef struct packed {
        logic  take;
        logic  set_fact;
        logic  divide;
        logic  put;
        logic  put_error;
        t_cond cond;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic bad;
        logic fit;
        logic out_full;
        logic more;
    } t_stat;

    // factorial, saturated at 2^RANK_W (above any rank)
    function automatic logic [FACT_W-1:0] fact_sat(input logic [SIZE_W-1:0] m);
        logic [FACT_W-1:0] f;
        case (m)
            SIZE_W'(0):  f = FACT_W'(1);
            SIZE_W'(1):  f = FACT_W'(1);
            SIZE_W'(2):  f = FACT_W'(2);
            SIZE_W'(3):  f = FACT_W'(6);
            SIZE_W'(4):  f = FACT_W'(24);
            SIZE_W'(5):  f = FACT_W'(120);
            SIZE_W'(6):  f = FACT_W'(720);
            SIZE_W'(7):  f = FACT_W'(5040);
            SIZE_W'(8):  f = FACT_W'(40320);
            SIZE_W'(9):  f = FACT_W'(362880);
            SIZE_W'(10): f = FACT_W'(3628800);
            SIZE_W'(11): f = FACT_W'(39916800);
            SIZE_W'(12): f = FACT_W'(479001600);
            default:     f = {1'b1, {RANK_W{1'b0}}};
        endcase
        return f;
    endfunction

    // microprogram
    function automatic t_ctrl ucode(input t_step s);
        t_ctrl c;
        c        = '0;
        c.cond   = C_NEXT;
        c.target = ST_IDLE;
        unique case (s)
            ST_IDLE: begin
                c.take   = 1'b1;
                c.cond   = C_NO_INPUT;
                c.target = ST_IDLE;
            end
            ST_CHECK: begin
                c.cond   = C_BAD;
                c.target = ST_ERR_WAIT;
            end
            ST_FACT: begin
                c.set_fact = 1'b1;
            end
            ST_DIV: begin
                c.divide = 1'b1;
                c.cond   = C_FIT;
                c.target = ST_DIV;
            end
            ST_WAIT: begin
                c.cond   = C_OUT_FULL;
                c.target = ST_WAIT;
            end
            ST_EMIT: begin
                c.put    = 1'b1;
                c.cond   = C_MORE;
                c.target = ST_FACT;
            end
            ST_DONE: begin
                c.cond   = C_ALWAYS;
                c.target = ST_IDLE;
            end
            ST_ERR_WAIT: begin
                c.cond   = C_OUT_FULL;
                c.target = ST_ERR_WAIT;
            end
            ST_ERR_EMIT: begin
                c.put_error = 1'b1;
                c.cond      = C_ALWAYS;
                c.target    = ST_IDLE;
            end
            default: begin
                c.cond   = C_ALWAYS;
                c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

### hdl/permutation_unrank.sv
// ----------------------------------------------------------------------------
// permutation_unrank
// Emits the k-th lexicographic permutation of 1..n, one element per word.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry {set_size, rank}. A word is
// taken only while the sequencer sits in its idle step, so one request is
// worked on at a time.
// Output channel: o_out_valid / i_out_stall carry {element, last,
// rank_error}, one word per element with last on the n-th.
// A rank of zero, above n!, or a set size of zero or above MAX_ELEMENTS
// gives one word with element 0, last and rank_error set, after the check
// step and the error wait step.
// Steps: for each position the microprogram loads the factorial, finds
// that position's quotient by subtracting the factorial once a cycle,
// waits for the output register and emits the word; the next request is
// taken after the last word.
// A stall holds the output register and the sequencer waits before each
// new word; nothing is lost.
// Reset clears the step counter and output valid; no other clearing.
// ----------------------------------------------------------------------------
module permutation_unrank #(
    parameter int MAX_ELEMENTS = pu_pkg::MAX_ELEMENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pu_pkg::t_in_word  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pu_pkg::t_out_word o_out_word
);

    pu_pkg::t_ctrl ctrl;
    pu_pkg::t_stat stat;

    pu_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    pu_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    assign o_in_stall = !ctrl.take;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while another is in progress");

    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.rank_error) |->
            (o_out_word.element == '0 && o_out_word.last))
        else $error("malformed error word");

    a_element_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.rank_error) |->
            (o_out_word.element != '0 && 32'(o_out_word.element) <= MAX_ELEMENTS))
        else $error("element out of range");

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.last) |-> o_in_stall)
        else $error("input open before permutation finished");

endmodule

### hdl/pu_seq.sv
// ----------------------------------------------------------------------------
// pu_seq
// Step counter and microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module pu_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pu_pkg::t_stat i_stat,
    output pu_pkg::t_ctrl o_ctrl
);

    pu_pkg::t_step r_step;
    pu_pkg::t_step n_step;
    pu_pkg::t_ctrl ctrl;
    logic          jump;

    always_comb begin
        ctrl = pu_pkg::ucode(r_step);
    end

    always_comb begin
        case (ctrl.cond)
            pu_pkg::C_ALWAYS:   jump = 1'b1;
            pu_pkg::C_NO_INPUT: jump = !i_stat.in_valid;
            pu_pkg::C_BAD:      jump = i_stat.bad;
            pu_pkg::C_FIT:      jump = i_stat.fit;
            pu_pkg::C_OUT_FULL: jump = i_stat.out_full;
            pu_pkg::C_MORE:     jump = i_stat.more;
            default:            jump = 1'b0;
        endcase
        n_step = jump ? ctrl.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= pu_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = ctrl;

endmodule

### hdl/pu_dp.sv
// ----------------------------------------------------------------------------
// pu_dp
// Rank divider by repeated subtraction, unused-value list and output register.
// ----------------------------------------------------------------------------
module pu_dp #(
    parameter int MAX_ELEMENTS = pu_pkg::MAX_ELEMENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pu_pkg::t_ctrl     i_ctrl,
    input  logic              i_in_valid,
    input  pu_pkg::t_in_word  i_in_word,
    output pu_pkg::t_stat     o_stat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pu_pkg::t_out_word o_out_word
);

    localparam int LIST_D = (MAX_ELEMENTS < 15) ? MAX_ELEMENTS : 15;

    logic                        r_bad;
    logic [pu_pkg::SIZE_W-1:0]   r_rem;
    logic [pu_pkg::RANK_W-1:0]   r_r;
    logic [pu_pkg::FACT_W-1:0]   r_f;
    logic [pu_pkg::SIZE_W-1:0]   r_q;
    logic [pu_pkg::ELEM_W-1:0]   r_list [LIST_D];
    logic                        r_out_valid;
    pu_pkg::t_out_word           r_out_word;

    logic                        accept;
    logic                        bad_in;
    logic                        fit;
    logic                        out_free;
    logic [pu_pkg::SIZE_W-1:0]   qi;
    logic [pu_pkg::ELEM_W-1:0]   pick;

    assign accept   = i_ctrl.take & i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;
    assign fit      = {1'b0, r_r} >= r_f;
    assign qi       = (r_q >= r_rem) ? r_rem - 1'b1 : r_q;

    always_comb begin
        bad_in = (i_in_word.set_size == '0)
              || (i_in_word.set_size > pu_pkg::SIZE_W'(LIST_D))
              || (i_in_word.rank == '0)
              || ({1'b0, i_in_word.rank} > pu_pkg::fact_sat(i_in_word.set_size));
    end

    always_comb begin
        pick = '0;
        for (int i = 0; i < LIST_D; i++) begin
            if (qi == pu_pkg::SIZE_W'(i)) begin
                pick = r_list[i];
            end
        end
    end

    always_comb begin
        o_stat.in_valid = i_in_valid;
        o_stat.bad      = r_bad;
        o_stat.fit      = fit;
        o_stat.out_full = !out_free;
        o_stat.more     = (r_rem != pu_pkg::SIZE_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.put || i_ctrl.put_error) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bad <= bad_in;
            r_rem <= i_in_word.set_size;
            r_r   <= i_in_word.rank - 1'b1;
            for (int i = 0; i < LIST_D; i++) begin
                r_list[i] <= pu_pkg::ELEM_W'(i + 1);
            end
        end
        if (i_ctrl.set_fact) begin
            r_f <= pu_pkg::fact_sat(r_rem - 1'b1);
            r_q <= '0;
        end
        if (i_ctrl.divide && fit) begin
            r_r <= r_r - r_f[pu_pkg::RANK_W-1:0];
            r_q <= r_q + 1'b1;
        end
        if (i_ctrl.put) begin
            r_out_word.element    <= pick;
            r_out_word.last       <= (r_rem == pu_pkg::SIZE_W'(1));
            r_out_word.rank_error <= 1'b0;
            r_rem                 <= r_rem - 1'b1;
            // close the gap left by the picked value
            for (int i = 0; i < LIST_D - 1; i++) begin
                if (pu_pkg::SIZE_W'(i) >= qi) begin
                    r_list[i] <= r_list[i+1];
                end
            end
        end
        if (i_ctrl.put_error) begin
            r_out_word.element    <= '0;
            r_out_word.last       <= 1'b1;
            r_out_word.rank_error <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
